/* rtl/bmhpq_pkg.sv */
// package: command and status codes, transfer structs and defaults for the heap queue
`timescale 1ns / 1ps
`default_nettype none

package bmhpq_pkg;

  localparam int unsigned DepthDef    = 256;
  localparam int unsigned KeyWidthDef = 32;

  localparam int unsigned CAP_W     = 9;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned KEY_IN_W  = 32;
  localparam int unsigned IDX_W     = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_PEEK     = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_INSERT   = 2'd2,
    CMD_DECREASE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_FULL       = 3'd2,
    ST_KEY_LARGER = 3'd3,
    ST_BAD_INDEX  = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [KEY_IN_W-1:0] key_value;
    logic [TAG_W-1:0]    entry_tag;
    logic [IDX_W-1:0]    node_index;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [KEY_IN_W-1:0] min_key;
    logic [TAG_W-1:0]    min_tag;
    logic [CNT_W-1:0]    entry_count;
    logic                is_empty;
  } res_t;

endpackage

`default_nettype wire

/* rtl/bmhpq_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/binary_min_heap_priority_queue.sv */
// top level: binary min-heap priority queue sequencer around one entry ram
// each command runs as a chain of states: a refused command is answered from idle, peek reads
// the root, insert climbs one level per step, decrease-key reads its node and then climbs
// likewise, or ends there if the new key is larger, and extract reads the root and the last
// entry, then descends one level per step; the one read port and a compare per read set the pace
// throughput: one command at a time, the next one is taken while the result strobe is up
// reset: count cleared, capacity 256, ram contents undefined; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_priority_queue
  import bmhpq_pkg::*;
#(
  parameter int unsigned DEPTH     = DepthDef,
  parameter int unsigned KEY_WIDTH = KeyWidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req_i,
  output logic                  done_o,
  output res_t                  res_o,
  input  wire logic             cap_we_i,
  input  wire logic [CAP_W-1:0] cap_wdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = KEY_WIDTH + TAG_W;
  localparam int unsigned CW = AW + 2;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_PEEK     = 11'b000_0000_0010,
    S_EXT_ROOT = 11'b000_0000_0100,
    S_EXT_LAST = 11'b000_0000_1000,
    S_DN_RDL   = 11'b000_0001_0000,
    S_DN_RDR   = 11'b000_0010_0000,
    S_DN_CMPR  = 11'b000_0100_0000,
    S_DN_MOVE  = 11'b000_1000_0000,
    S_UP       = 11'b001_0000_0000,
    S_UP_CMP   = 11'b010_0000_0000,
    S_DEC      = 11'b100_0000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CAP_W-1:0]     cap_q;
  logic [AW-1:0]        pos_q, pos_d;
  logic [KEY_WIDTH-1:0] mv_key_q, mv_key_d;
  logic [TAG_W-1:0]     mv_tag_q, mv_tag_d;
  logic [KEY_WIDTH-1:0] cd_key_q, cd_key_d;
  logic [TAG_W-1:0]     cd_tag_q, cd_tag_d;
  logic [AW-1:0]        cd_pos_q, cd_pos_d;
  logic                 cd_mv_q, cd_mv_d;
  status_e              st_q, st_d;
  logic [KEY_WIDTH-1:0] rk_q, rk_d;
  logic [TAG_W-1:0]     rt_q, rt_d;
  logic                 done_q, done_d;
  res_t                 res_q, res_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [TAG_W-1:0]     rd_tag;
  logic [KEY_WIDTH-1:0] in_key;
  logic [CW-1:0]        left_pos, right_pos;
  logic [AW-1:0]        par_pos;
  logic                 left_in, right_in;
  logic                 accept, full, fin;

  assign rd_key    = ram_rdata[EW-1:TAG_W];
  assign rd_tag    = ram_rdata[TAG_W-1:0];
  assign in_key    = KEY_WIDTH'(req_i.key_value);
  assign left_pos  = {1'b0, pos_q, 1'b1};
  assign right_pos = left_pos + CW'(1);
  assign par_pos   = (pos_q - AW'(1)) >> 1;
  assign left_in   = 32'(left_pos) < 32'(cnt_q);
  assign right_in  = 32'(right_pos) < 32'(cnt_q);
  assign accept    = start && !busy;
  assign full      = (cnt_q >= cap_q) || (32'(cnt_q) >= DEPTH);
  assign busy      = (state_q != S_IDLE);

  bmhpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    mv_key_d  = mv_key_q;
    mv_tag_d  = mv_tag_q;
    cd_key_d  = cd_key_q;
    cd_tag_d  = cd_tag_q;
    cd_pos_d  = cd_pos_q;
    cd_mv_d   = cd_mv_q;
    st_d      = st_q;
    rk_d      = rk_q;
    rt_d      = rt_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {mv_key_q, mv_tag_q};
    ram_raddr = '0;
    fin       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d     = ST_OK;
          rk_d     = '0;
          rt_d     = '0;
          mv_key_d = in_key;
          mv_tag_d = req_i.entry_tag;
          case (req_i.cmd)
            CMD_PEEK, CMD_EXTRACT: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
                fin  = 1'b1;
              end else begin
                ram_raddr = '0;
                if (req_i.cmd == CMD_EXTRACT) begin
                  cnt_d   = cnt_q - CNT_W'(1);
                  state_d = S_EXT_ROOT;
                end else begin
                  state_d = S_PEEK;
                end
              end
            end
            CMD_INSERT: begin
              if (full) begin
                st_d = ST_FULL;
                fin  = 1'b1;
              end else begin
                pos_d   = AW'(cnt_q);
                cnt_d   = cnt_q + CNT_W'(1);
                state_d = S_UP;
              end
            end
            CMD_DECREASE: begin
              if ({1'b0, req_i.node_index} >= cnt_q) begin
                st_d = ST_BAD_INDEX;
                fin  = 1'b1;
              end else begin
                pos_d     = AW'(req_i.node_index);
                ram_raddr = AW'(req_i.node_index);
                state_d   = S_DEC;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        rk_d = rd_key;
        rt_d = rd_tag;
        fin  = 1'b1;
      end
      S_EXT_ROOT: begin
        rk_d = rd_key;
        rt_d = rd_tag;
        if (cnt_q == '0) begin
          fin = 1'b1;
        end else begin
          ram_raddr = AW'(cnt_q);
          state_d   = S_EXT_LAST;
        end
      end
      S_EXT_LAST: begin
        mv_key_d = rd_key;
        mv_tag_d = rd_tag;
        pos_d    = '0;
        state_d  = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (left_in) begin
          ram_raddr = AW'(left_pos);
          state_d   = S_DN_RDR;
        end else begin
          ram_we = 1'b1;
          fin    = 1'b1;
        end
      end
      S_DN_RDR: begin
        if (rd_key < mv_key_q) begin
          cd_key_d = rd_key;
          cd_tag_d = rd_tag;
          cd_pos_d = AW'(left_pos);
          cd_mv_d  = 1'b1;
        end else begin
          cd_key_d = mv_key_q;
          cd_tag_d = mv_tag_q;
          cd_pos_d = pos_q;
          cd_mv_d  = 1'b0;
        end
        if (right_in) begin
          ram_raddr = AW'(right_pos);
          state_d   = S_DN_CMPR;
        end else begin
          state_d = S_DN_MOVE;
        end
      end
      S_DN_CMPR: begin
        if (rd_key < cd_key_q) begin
          cd_key_d = rd_key;
          cd_tag_d = rd_tag;
          cd_pos_d = AW'(right_pos);
          cd_mv_d  = 1'b1;
        end
        state_d = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        ram_we = 1'b1;
        if (cd_mv_q) begin
          ram_wdata = {cd_key_q, cd_tag_q};
          pos_d     = cd_pos_q;
          state_d   = S_DN_RDL;
        end else begin
          fin = 1'b1;
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          ram_we = 1'b1;
          fin    = 1'b1;
        end else begin
          ram_raddr = par_pos;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (mv_key_q < rd_key) begin
          ram_wdata = ram_rdata;
          pos_d     = par_pos;
          state_d   = S_UP;
        end else begin
          fin = 1'b1;
        end
      end
      S_DEC: begin
        if (mv_key_q > rd_key) begin
          st_d = ST_KEY_LARGER;
          fin  = 1'b1;
        end else begin
          state_d = S_UP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    done_d = fin;
    if (fin) begin
      state_d           = S_IDLE;
      res_d.status      = st_d;
      res_d.min_key     = KEY_IN_W'(rk_d);
      res_d.min_tag     = rt_d;
      res_d.entry_count = cnt_d;
      res_d.is_empty    = (cnt_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cap_q   <= CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cap_we_i) begin
        cap_q <= cap_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    mv_key_q <= mv_key_d;
    mv_tag_q <= mv_tag_d;
    cd_key_q <= cd_key_d;
    cd_tag_q <= cd_tag_d;
    cd_pos_q <= cd_pos_d;
    cd_mv_q  <= cd_mv_d;
    st_q     <= st_d;
    rk_q     <= rk_d;
    rt_q     <= rt_d;
    res_q    <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // a result only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a command is in progress");

  // the entry count never passes the ram depth
  a_cnt_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("entry count beyond depth");

  // an extract on a non-empty heap drops the count by one right away
  a_ext_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.cmd == CMD_EXTRACT && cnt_q != '0) |=>
      (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("extract did not remove an entry");

  // the ram is written only by a command in flight
  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy)
    else $error("ram write while idle");

endmodule

`default_nettype wire
